@@ sv/moving_window_linear_fit_core_assert.svh @@
`ifndef MOVING_WINDOW_LINEAR_FIT_CORE_ASSERT_SVH
`define MOVING_WINDOW_LINEAR_FIT_CORE_ASSERT_SVH

// ante implies cons in the same cycle
`define MWLF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define MWLF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/mwlf_pkg.sv @@
package mwlf_pkg;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic CFG_WINDOW  = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [6:0]  WINDOW_RESET  = 7'd64;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    typedef struct packed {
        logic               opcode;
        logic        [15:0] sample_time;
        logic signed [15:0] sample_value;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] fitted_value;
        logic        [6:0]  samples_held;
        logic               saturated;
    } t_out_rsp;

endpackage

@@ sv/moving_window_linear_fit_core.sv @@
// An append evicts the oldest samples while the window is full, adds its sample to the sums, then
// runs seven multiply passes on one shared multiplier and the 17-step divider; it stops after two
// passes when all held times are equal, skips the divider when clipped, and skips both with one
// sample held. One request at a time: the next is accepted the cycle after the result loads;
// a tick evicts one sample when its gap exceeds the timeout.
// Reset: window and sums empty, window_size 64, timeout_ticks 100; ring contents undefined.
module moving_window_linear_fit_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mwlf_pkg::t_in_req i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mwlf_pkg::t_out_rsp o_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import mwlf_pkg::*;

    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int SW    = 16 + CW;
    localparam int QW    = 32 + CW;
    localparam int VW    = 33 + CW;
    localparam int BW    = 16 + CW;
    localparam int WW    = 2 * CW + 54;
    localparam int NSTEP = (BW + 7) / 8;
    localparam int KW    = $clog2(NSTEP + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_EVRD  = 4'd2;
    localparam logic [3:0] S_EVSUB = 4'd3;
    localparam logic [3:0] S_ADD   = 4'd4;
    localparam logic [3:0] S_MLD   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_MST   = 4'd7;
    localparam logic [3:0] S_DPREP = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    localparam logic [2:0] MI_NSTT = 3'd0;
    localparam logic [2:0] MI_STST = 3'd1;
    localparam logic [2:0] MI_NSTV = 3'd2;
    localparam logic [2:0] MI_STSV = 3'd3;
    localparam logic [2:0] MI_AT   = 3'd4;
    localparam logic [2:0] MI_STTV = 3'd5;
    localparam logic [2:0] MI_STTV2 = 3'd6;

    logic [31:0] r_mem [MAX_WINDOW];
    logic [31:0] r_rdata;

    logic [3:0]  r_state;
    logic [6:0]  r_ws;
    logic [15:0] r_timeout;
    logic        r_op;
    logic [15:0] r_t;
    logic signed [15:0] r_v;
    logic [AW-1:0] r_oldest;
    logic [CW-1:0] r_held;
    logic [SW-1:0] r_st;
    logic [QW-1:0] r_stt;
    logic signed [SW-1:0] r_sv;
    logic signed [VW-1:0] r_stv;
    logic [15:0] r_last;
    logic [31:0] r_ptt;
    logic signed [31:0] r_ptv;

    logic [2:0]  r_mi;
    logic [WW-1:0] r_ma;
    logic [BW-1:0] r_mb;
    logic        r_msg;
    logic [WW-1:0] r_acc;
    logic [KW-1:0] r_step;
    logic signed [WW-1:0] r_d;
    logic signed [WW-1:0] r_a;
    logic signed [WW-1:0] r_num;
    logic [WW-1:0] r_m;
    logic [WW-1:0] r_dv;
    logic [16:0] r_q;
    logic [4:0]  r_bit;
    logic        r_neg;
    logic signed [15:0] r_fit;
    logic        r_sat;
    logic        r_ov;
    t_out_rsp    r_out;

    logic [CW-1:0] effw;
    logic [AW+1:0] slot_sum;
    logic [AW-1:0] slot;
    logic [15:0]   rd_t;
    logic signed [15:0] rd_v;
    logic signed [WW-1:0] a_op;
    logic signed [BW:0]   b_op;
    logic signed [WW-1:0] prod;
    logic signed [WW-1:0] n_d;
    logic [WW-1:0] num_mag;
    logic [WW-1:0] n_m;
    logic [WW-1:0] lim;
    logic          ge;
    logic [16:0]   n_q;
    logic [15:0]   t_gap;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_ws == 7'd0) begin
            effw = CW'(1);
        end else if (int'(r_ws) > MAX_WINDOW) begin
            effw = CW'(MAX_WINDOW);
        end else begin
            effw = CW'(r_ws);
        end
        slot_sum = (AW + 2)'(r_oldest) + (AW + 2)'(r_held);
        if (slot_sum >= (AW + 2)'(MAX_WINDOW)) begin
            slot = AW'(slot_sum - (AW + 2)'(MAX_WINDOW));
        end else begin
            slot = AW'(slot_sum);
        end
        rd_t  = r_rdata[31:16];
        rd_v  = $signed(r_rdata[15:0]);
        t_gap = i_in.sample_time - r_last;
    end

    always_comb begin
        case (r_mi)
            MI_NSTT: begin
                a_op = $signed(WW'(r_stt));
                b_op = $signed((BW + 1)'(r_held));
            end
            MI_STST: begin
                a_op = $signed(WW'(r_st));
                b_op = $signed((BW + 1)'(r_st));
            end
            MI_NSTV: begin
                a_op = WW'(r_stv);
                b_op = $signed((BW + 1)'(r_held));
            end
            MI_STSV: begin
                a_op = WW'(r_sv);
                b_op = $signed((BW + 1)'(r_st));
            end
            MI_AT: begin
                a_op = r_a;
                b_op = $signed((BW + 1)'(r_t));
            end
            MI_STTV: begin
                a_op = $signed(WW'(r_stt));
                b_op = (BW + 1)'(r_sv);
            end
            default: begin
                a_op = WW'(r_stv);
                b_op = $signed((BW + 1)'(r_st));
            end
        endcase
        prod    = r_msg ? -$signed(r_acc) : $signed(r_acc);
        n_d     = r_d - prod;
        num_mag = r_num[WW-1] ? WW'(-r_num) : WW'(r_num);
        n_m     = (num_mag << 1) + WW'(r_d);
        lim     = (WW'(r_d) << 16) + (r_num[WW-1] ? (WW'(r_d) << 1) : '0);
        ge      = (r_m >= r_dv);
        n_q     = {r_q[15:0], ge};
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_oldest];
        if (r_state == S_CHK && r_held < effw) begin
            r_mem[slot] <= {r_t, r_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ws      <= WINDOW_RESET;
            r_timeout <= TIMEOUT_RESET;
            r_oldest  <= '0;
            r_held    <= '0;
            r_st      <= '0;
            r_stt     <= '0;
            r_sv      <= '0;
            r_stv     <= '0;
            r_last    <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WINDOW) begin
                    r_ws <= i_cfg_data[6:0];
                end else begin
                    r_timeout <= i_cfg_data;
                end
            end
            if (r_state == S_OUT && (!r_ov || i_out_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op <= i_in.opcode;
                        r_t  <= i_in.sample_time;
                        r_v  <= i_in.sample_value;
                        if (i_in.opcode == OP_APPEND) begin
                            r_state <= S_CHK;
                        end else if (t_gap > r_timeout) begin
                            r_last <= i_in.sample_time;
                            if (r_held != '0) begin
                                r_state <= S_EVRD;
                            end
                        end
                    end
                end
                S_CHK: begin
                    if (r_held >= effw) begin
                        r_state <= S_EVRD;
                    end else begin
                        r_ptt   <= 32'(r_t * r_t);
                        r_ptv   <= 32'($signed({1'b0, r_t}) * r_v);
                        r_state <= S_ADD;
                    end
                end
                S_EVRD: begin
                    r_ptt   <= 32'(rd_t * rd_t);
                    r_ptv   <= 32'($signed({1'b0, rd_t}) * rd_v);
                    r_state <= S_EVSUB;
                end
                S_EVSUB: begin
                    r_st   <= r_st - SW'(rd_t);
                    r_stt  <= r_stt - QW'(r_ptt);
                    r_sv   <= r_sv - SW'(rd_v);
                    r_stv  <= r_stv - VW'(r_ptv);
                    r_held <= r_held - CW'(1);
                    r_oldest <= (r_oldest == AW'(MAX_WINDOW - 1)) ? '0 : r_oldest + AW'(1);
                    r_state  <= (r_op == OP_TICK) ? S_IDLE : S_CHK;
                end
                S_ADD: begin
                    r_st   <= r_st + SW'(r_t);
                    r_stt  <= r_stt + QW'(r_ptt);
                    r_sv   <= r_sv + SW'(r_v);
                    r_stv  <= r_stv + VW'(r_ptv);
                    r_held <= r_held + CW'(1);
                    r_last <= r_t;
                    r_mi   <= MI_NSTT;
                    r_fit  <= r_v;
                    r_sat  <= 1'b0;
                    r_state <= (r_held == '0) ? S_OUT : S_MLD;
                end
                S_MLD: begin
                    r_ma    <= a_op[WW-1] ? WW'(-a_op) : WW'(a_op);
                    r_mb    <= b_op[BW] ? BW'(-b_op) : BW'(b_op);
                    r_msg   <= a_op[WW-1] ^ b_op[BW];
                    r_acc   <= '0;
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc  <= r_acc + WW'(r_ma * r_mb[7:0]);
                    r_ma   <= r_ma << 8;
                    r_mb   <= r_mb >> 8;
                    r_step <= r_step + KW'(1);
                    if (r_step == KW'(NSTEP - 1)) begin
                        r_state <= S_MST;
                    end
                end
                S_MST: begin
                    r_mi <= r_mi + 3'd1;
                    case (r_mi)
                        MI_NSTT: begin
                            r_d     <= prod;
                            r_state <= S_MLD;
                        end
                        MI_STST: begin
                            r_d     <= n_d;
                            r_state <= (n_d <= 0) ? S_OUT : S_MLD;
                        end
                        MI_NSTV: begin
                            r_a     <= prod;
                            r_state <= S_MLD;
                        end
                        MI_STSV: begin
                            r_a     <= r_a - prod;
                            r_state <= S_MLD;
                        end
                        MI_AT: begin
                            r_num   <= prod;
                            r_state <= S_MLD;
                        end
                        MI_STTV: begin
                            r_num   <= r_num + prod;
                            r_state <= S_MLD;
                        end
                        MI_STTV2: begin
                            r_num   <= r_num - prod;
                            r_state <= S_DPREP;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_DPREP: begin
                    r_neg <= r_num[WW-1];
                    r_m   <= n_m;
                    r_dv  <= WW'(r_d) << 17;
                    r_q   <= '0;
                    r_bit <= 5'd16;
                    if (n_m >= lim) begin
                        r_fit   <= r_num[WW-1] ? -16'sd32768 : 16'sd32767;
                        r_sat   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (ge) begin
                        r_m <= r_m - r_dv;
                    end
                    r_q   <= n_q;
                    r_dv  <= r_dv >> 1;
                    r_bit <= r_bit - 5'd1;
                    if (r_bit == 5'd0) begin
                        r_fit   <= r_neg ? -$signed(n_q[15:0]) : $signed(n_q[15:0]);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || i_out_ready) begin
                        r_out <= '{fitted_value: r_fit, samples_held: 7'(r_held),
                                   saturated: r_sat};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`include "moving_window_linear_fit_core_assert.svh"

    `MWLF_ASSERT_NOW(a_held_bound, 1'b1, int'(r_held) <= MAX_WINDOW, "held count overflow")
    `MWLF_ASSERT_NOW(a_out_nonempty, r_ov, r_out.samples_held != 7'd0, "empty window result")
    `MWLF_ASSERT_NOW(a_sat_limit, r_ov && r_out.saturated,
        r_out.fitted_value == 16'sd32767 || r_out.fitted_value == -16'sd32768, "bad clip")
    `MWLF_ASSERT_NEXT(a_out_load, r_state == S_OUT && (!r_ov || i_out_ready),
        r_ov && r_state == S_IDLE, "result not loaded")

endmodule

@@ test/testbench.sv @@
module testbench;
    import mwlf_pkg::*;

    localparam int  RING_DEPTH  = 64;
    localparam int  PHASE_ITEMS = 250;
    localparam longint CYCLE_LIMIT = 3_000_000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_rsp o_out;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    logic     i_cfg_index;
    logic [15:0] i_cfg_data;

    moving_window_linear_fit_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_in_req  pending_reqs[$];
    t_out_rsp expected_fits[$];
    int       mismatch_count;
    int       failure_count;
    longint   cycle_count;
    logic     in_taken;
    logic     cfg_taken;
    int       burst_left;
    int       gap_left;
    int       stall_mode;

    logic [15:0]        ring_time[RING_DEPTH];
    logic signed [15:0] ring_value[RING_DEPTH];
    int                 ring_oldest;
    int                 ring_count;
    longint             sum_t, sum_tt, sum_v, sum_tv;
    logic [15:0]        last_update;
    logic [6:0]         window_reg;
    logic [15:0]        timeout_reg;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int window_limit();
        if (window_reg == 0) return 1;
        if (window_reg > RING_DEPTH) return RING_DEPTH;
        return window_reg;
    endfunction

    task automatic drop_oldest();
        longint t, v;
        if (ring_count == 0) return;
        t = ring_time[ring_oldest];
        v = ring_value[ring_oldest];
        sum_t  -= t;
        sum_tt -= t * t;
        sum_v  -= v;
        sum_tv -= t * v;
        ring_oldest = (ring_oldest + 1) % RING_DEPTH;
        ring_count--;
    endtask

    task automatic predict_fit(input t_in_req req);
        int                  slot;
        longint              n, t, v, det, a;
        logic signed [127:0] num, mag, m, q, lim;
        logic                neg;
        t_out_rsp            rsp;
        if (req.opcode == OP_TICK) begin
            if (16'(req.sample_time - last_update) > timeout_reg) begin
                drop_oldest();
                last_update = req.sample_time;
            end
            return;
        end
        while (ring_count >= window_limit()) drop_oldest();
        slot = (ring_oldest + ring_count) % RING_DEPTH;
        ring_time[slot]  = req.sample_time;
        ring_value[slot] = req.sample_value;
        ring_count++;
        t = req.sample_time;
        v = req.sample_value;
        sum_t  += t;
        sum_tt += t * t;
        sum_v  += v;
        sum_tv += t * v;
        last_update = req.sample_time;
        n   = ring_count;
        det = n * sum_tt - sum_t * sum_t;
        rsp.fitted_value = req.sample_value;
        rsp.samples_held = 7'(ring_count);
        rsp.saturated    = 1'b0;
        if (ring_count > 1 && det > 0) begin
            a   = n * sum_tv - sum_t * sum_v;
            num = 128'(a) * 128'(t) + (128'(sum_tt) * 128'(sum_v) - 128'(sum_t) * 128'(sum_tv));
            neg = num < 0;
            mag = neg ? -num : num;
            m   = 2 * mag + 128'(det);
            q   = m / (2 * 128'(det));
            lim = neg ? 128'sd32768 : 128'sd32767;
            if (q > lim) begin
                q = lim;
                rsp.saturated = 1'b1;
            end
            rsp.fitted_value = 16'(neg ? -q : q);
        end
        expected_fits.push_back(rsp);
    endtask

    function automatic logic i_out_valid_ok();
        return o_out_valid === 1'b1 && i_out_ready;
    endfunction

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_out_rsp exp_rsp;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
        in_taken  <= i_rst_n && i_in_valid && o_in_ready;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WINDOW) window_reg = i_cfg_data[6:0];
                else timeout_reg = i_cfg_data;
            end
            if (i_out_valid_ok()) begin
                if (expected_fits.size() == 0) begin
                    failure_count++;
                    if (mismatch_count + failure_count <= 10)
                        $display("unexpected result %p", o_out);
                end else begin
                    exp_rsp = expected_fits.pop_front();
                    if (o_out.fitted_value !== exp_rsp.fitted_value
                        || o_out.samples_held !== exp_rsp.samples_held
                        || o_out.saturated !== exp_rsp.saturated) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                exp_rsp.fitted_value, exp_rsp.samples_held,
                                exp_rsp.saturated, o_out.fitted_value,
                                o_out.samples_held, o_out.saturated);
                    end
                end
            end
            if (i_in_valid && o_in_ready) predict_fit(i_in);
        end
    end

    // driver: bursts of requests with random gaps
    always @(negedge i_clk) begin
        logic     next_valid;
        t_in_req  next_req;
        next_valid = i_in_valid;
        next_req   = i_in;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_in_valid || in_taken) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 24);
                next_req   = pending_reqs.pop_front();
                next_valid = 1'b1;
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        i_in_valid <= next_valid;
        i_in       <= next_req;
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= cycle_count[0];
            end
            2: begin
                i_out_ready <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                i_out_ready <= (cycle_count % 40) > 25;
            end
        endcase
    end

    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() > 0 || i_in_valid || expected_fits.size() > 0);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic t_in_req make_req(logic op, logic [15:0] t, int v);
        t_in_req r;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.opcode       = op;
        r.sample_time  = t;
        r.sample_value = 16'(v);
        return r;
    endfunction

    task automatic fill_random(input int count);
        logic [15:0] now;
        int          level, slope, pick;
        now   = $urandom;
        level = $urandom_range(0, 20000) - 10000;
        slope = $urandom_range(0, 400) - 200;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                now += ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
                pending_reqs.push_back(make_req(OP_TICK, now, $urandom));
            end else if (pick < 85) begin
                now   += $urandom_range(0, 40);
                level += slope * $urandom_range(0, 4) + $urandom_range(0, 200) - 100;
                if (level > 40000 || level < -40000) slope = -slope;
                pending_reqs.push_back(make_req(OP_APPEND, now, level));
            end else begin
                now = $urandom;
                pending_reqs.push_back(make_req(OP_APPEND, now, $signed(16'($urandom))));
            end
        end
    endtask

    initial begin
        logic [15:0] windows[8];
        logic [15:0] timeouts[8];
        windows  = '{16'd64, 16'd1, 16'd2, 16'd3, 16'd0, 16'hFF7F, 16'd64, 16'd17};
        timeouts = '{16'd100, 16'd0, 16'hFFFF, 16'd5, 16'd300, 16'd40, 16'd1000, 16'd20};
        mismatch_count = 0;
        failure_count  = 0;
        cycle_count    = 0;
        in_taken       = 1'b0;
        cfg_taken      = 1'b0;
        burst_left     = 0;
        gap_left       = 0;
        stall_mode     = 0;
        ring_oldest    = 0;
        ring_count     = 0;
        sum_t = 0; sum_tt = 0; sum_v = 0; sum_tv = 0;
        last_update    = '0;
        window_reg     = WINDOW_RESET;
        timeout_reg    = TIMEOUT_RESET;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_WINDOW;
        i_cfg_data     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: tick on empty window, single sample, equal times, extremes
        pending_reqs.push_back(make_req(OP_TICK, 16'd500, 0));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd0, -32768));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd0, 32767));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd1, 32767));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd2, -32768));
        pending_reqs.push_back(make_req(OP_APPEND, 16'hFFFF, 0));
        pending_reqs.push_back(make_req(OP_APPEND, 16'hFFFF, 32767));
        pending_reqs.push_back(make_req(OP_TICK, 16'hFFFF, 0));
        pending_reqs.push_back(make_req(OP_TICK, 16'd200, 0));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd210, -1));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd220, 100));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd230, -32768));
        pending_reqs.push_back(make_req(OP_APPEND, 16'd5, 1));
        drain();

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_WINDOW, windows[p]);
            write_reg(CFG_TIMEOUT, timeouts[p]);
            fill_random(PHASE_ITEMS);
            drain();
        end

        repeat (300) @(negedge i_clk);
        if (mismatch_count == 0 && failure_count == 0 && expected_fits.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule
